FILE: hdl/fdma_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fdma_pkg
// Shared constants, types and codes of the multichannel NCO mixer.
// -----------------------------------------------------------------------------
package fdma_pkg;

  localparam int NUM_CHANNELS = 14;
  localparam int TABLE_DEPTH  = 8192;
  localparam int PHASE_BITS   = 32;

  localparam int TBL_BITS = $clog2(TABLE_DEPTH);
  localparam int CH_HALF  = NUM_CHANNELS / 2;
  localparam int LANE_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LCNT_W   = $clog2(NUM_CHANNELS + 1);

  localparam int MASK_W    = 14;
  localparam int AMP_W     = 11;
  localparam int STEP_W    = 32;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = SAMPLE_W + $clog2(NUM_CHANNELS) + 1;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
    32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860
  };

  localparam int CMD_DEPTH = 4;

  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_MASK  = 3'd0,
    REG_CHANNEL_STEP = 3'd1,
    REG_CHIP_STEP    = 3'd2,
    REG_LO_STEP      = 3'd3,
    REG_AMPLITUDE    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [MASK_W-1:0]        active_mask;
    logic [STEP_W-1:0]        channel_step;
    logic [STEP_W-1:0]        chip_step;
    logic signed [STEP_W-1:0] lo_step;
    logic [AMP_W-1:0]         amplitude;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic              lo;
    logic [LANE_W-1:0] lane;
  } tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_CLAMP,
    ST_MIX,
    ST_FINISH
  } eng_state_e;

endpackage
`default_nettype wire

FILE: hdl/fdma_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fdma_front
// Input side: takes sample ticks, turns them into commands and queues them
// for the synthesis engine.
// -----------------------------------------------------------------------------
module fdma_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire logic           clear_phase_i,
  input  wire logic           chunk_last_i,
  output logic                cmd_valid_o,
  output fdma_pkg::cmd_t      cmd_o,
  input  wire logic           cmd_pop_i
);
  import fdma_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_q [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en, rd_en;
  cmd_t             cmd_in;

  assign full_o      = (count_q == CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  assign wr_en = push_i && !full_o;
  assign rd_en = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.clear = clear_phase_i;
    cmd_in.last  = chunk_last_i;
    wr_ptr_d = wr_en ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fdma_cordic.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fdma_cordic
// Pipelined phase-to-cos/sin unit: quadrant fold, 16 CORDIC stages, Q15
// rounding. One phase per cycle, results in order, tag carried alongside.
// -----------------------------------------------------------------------------
module fdma_cordic (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire fdma_pkg::phase_t in_phase_i,
  input  wire fdma_pkg::tag_t   in_tag_i,
  output logic                  out_valid_o,
  output fdma_pkg::tag_t        out_tag_o,
  output fdma_pkg::sample_t     out_cos_o,
  output fdma_pkg::sample_t     out_sin_o
);
  import fdma_pkg::*;

  localparam int MUL_W = 48;
  localparam logic signed [MUL_W-1:0] Q15_HALF = 48'sd536870912;
  localparam logic signed [MUL_W-1:0] Q15_MAX  = 48'sd32767;
  localparam logic signed [MUL_W-1:0] Q15_MIN  = -48'sd32767;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS+1];
  quad_e                      quad_q [CORDIC_STEPS+1];
  tag_t                       tag_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]      vld_q;

  logic signed [MUL_W-1:0] mx_q, my_q;
  quad_e                   mquad_q;
  tag_t                    mtag_q;
  logic                    mvld_q;

  logic [31:0] ang;
  sample_t     c_r, s_r;
  sample_t     cos_d, sin_d;

  // table index back to a 32-bit angle: low phase bits dropped
  assign ang = {in_phase_i[PHASE_BITS-1 -: TBL_BITS], {(32-TBL_BITS){1'b0}}};

  function automatic sample_t to_q15(input logic signed [MUL_W-1:0] m);
    logic signed [MUL_W-1:0] r;
    r = (m + Q15_HALF) >>> 30;
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end else if (r < Q15_MIN) begin
      r = Q15_MIN;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CORDIC_START;
    y_q[0]    <= '0;
    z_q[0]    <= $signed({2'b00, ang[29:0]});
    quad_q[0] <= quad_e'(ang[31:30]);
    tag_q[0]  <= in_tag_i;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (!z_q[i][CORDIC_W-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN_TURNS[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN_TURNS[i];
      end
      quad_q[i+1] <= quad_q[i];
      tag_q[i+1]  <= tag_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= {{(MUL_W-CORDIC_W){x_q[CORDIC_STEPS][CORDIC_W-1]}}, x_q[CORDIC_STEPS]}
            * 48'd32767;
    my_q <= {{(MUL_W-CORDIC_W){y_q[CORDIC_STEPS][CORDIC_W-1]}}, y_q[CORDIC_STEPS]}
            * 48'd32767;
    mquad_q <= quad_q[CORDIC_STEPS];
    mtag_q  <= tag_q[CORDIC_STEPS];
  end

  always_comb begin
    c_r = to_q15(mx_q);
    s_r = to_q15(my_q);
    unique case (mquad_q)
      QUAD_0: begin cos_d = c_r;  sin_d = s_r;  end
      QUAD_1: begin cos_d = -s_r; sin_d = c_r;  end
      QUAD_2: begin cos_d = -c_r; sin_d = -s_r; end
      QUAD_3: begin cos_d = s_r;  sin_d = -c_r; end
      default: begin cos_d = c_r; sin_d = s_r; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_cos_o <= cos_d;
    out_sin_o <= sin_d;
    out_tag_o <= mtag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      mvld_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      vld_q       <= {vld_q[CORDIC_STEPS-1:0], in_valid_i};
      mvld_q      <= vld_q[CORDIC_STEPS];
      out_valid_o <= mvld_q;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fdma_engine.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fdma_engine
// Back end: per sample, steps the phase accumulators, streams the lane phases
// and the LO phase through the shared rotator, sums the enabled lanes, mixes
// with the LO when the LO step is nonzero, and holds the result until it is taken.
// -----------------------------------------------------------------------------
module fdma_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fdma_pkg::cfg_t   cfg_i,
  input  wire logic             cmd_valid_i,
  input  wire fdma_pkg::cmd_t   cmd_i,
  output logic                  cmd_pop_o,
  input  wire logic             res_pop_i,
  output logic                  res_valid_o,
  output fdma_pkg::sample_t     i_sample_o,
  output fdma_pkg::sample_t     q_sample_o,
  output logic                  saturated_o,
  output logic                  last_o
);
  import fdma_pkg::*;

  localparam int WIDE_W  = 34;
  localparam int PROD_W  = AMP_W + 1 + SAMPLE_W;
  localparam logic [LCNT_W-1:0] LAST_CNT = LCNT_W'(NUM_CHANNELS);

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef struct packed {
    sample_t val;
    logic    hit;
  } clamp_t;

  localparam wide_t SMAX = 34'sd32767;
  localparam wide_t SMIN = -34'sd32768;

  eng_state_e state_q, state_d;

  logic [LCNT_W-1:0]        cnt_q;
  logic                     clear_q, last_q;
  logic signed [AMP_W:0]    sym_q;
  phase_t                   inc_q;
  phase_t                   chan_q [NUM_CHANNELS];
  phase_t                   chip_q, lo_q, lo_issue_q;
  logic signed [SUM_W-1:0]  sum_i_q, sum_q_q;
  sample_t                  lo_c_q, lo_s_q;
  sample_t                  oi_q, oq_q;
  logic                     sat1_q;
  logic signed [31:0]       p_ic_q, p_qs_q, p_is_q, p_qc_q;
  logic                     res_valid_q;

  logic                     issue_valid;
  phase_t                   issue_phase;
  tag_t                     issue_tag;
  logic                     res_write;

  logic                     cor_valid;
  tag_t                     cor_tag;
  sample_t                  cor_cos, cor_sin;

  logic [LANE_W-1:0]        lane_idx;
  phase_t                   chan_eff, chip_eff, lo_eff, step_p, inc0;
  logic                     chip_pos;
  logic [NUM_CHANNELS-1:0]  lane_en;
  logic signed [PROD_W-1:0] prod_i, prod_q;
  clamp_t                   cl_i, cl_q, mx_i, mx_q;

  function automatic wide_t trunc_q15(input wide_t v);
    if (v < 0) begin
      return (v + SMAX) >>> 15;
    end
    return v >>> 15;
  endfunction

  function automatic clamp_t clamp16(input wide_t v);
    clamp_t r;
    r.hit = 1'b0;
    if (v > SMAX) begin
      r.val = SMAX[SAMPLE_W-1:0];
      r.hit = 1'b1;
    end else if (v < SMIN) begin
      r.val = SMIN[SAMPLE_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  fdma_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (issue_valid),
    .in_phase_i  (issue_phase),
    .in_tag_i    (issue_tag),
    .out_valid_o (cor_valid),
    .out_tag_o   (cor_tag),
    .out_cos_o   (cor_cos),
    .out_sin_o   (cor_sin)
  );

  assign lane_idx = cnt_q[LANE_W-1:0];
  assign lane_en  = NUM_CHANNELS'(cfg_i.active_mask);
  assign step_p   = PHASE_BITS'(cfg_i.channel_step);
  assign inc0     = phase_t'(0) - phase_t'(PHASE_BITS'(CH_HALF) * step_p);
  assign chan_eff = clear_q ? '0 : chan_q[lane_idx];
  assign chip_eff = cmd_i.clear ? '0 : chip_q;
  assign lo_eff   = cmd_i.clear ? '0 : lo_q;
  // symbol is positive strictly inside (-1/4, +1/4) turn
  assign chip_pos = (chip_eff[PHASE_BITS-1 -: 2] == 2'b00) ||
                    ((chip_eff[PHASE_BITS-1 -: 2] == 2'b11) && |chip_eff[PHASE_BITS-3:0]);
  assign prod_i   = sym_q * cor_cos;
  assign prod_q   = sym_q * cor_sin;

  always_comb begin
    cl_i = clamp16(wide_t'(sum_i_q));
    cl_q = clamp16(wide_t'(sum_q_q));
    mx_i = clamp16(trunc_q15(wide_t'(p_ic_q) - wide_t'(p_qs_q)));
    mx_q = clamp16(trunc_q15(wide_t'(p_is_q) + wide_t'(p_qc_q)));
  end

  always_comb begin
    state_d        = state_q;
    cmd_pop_o      = 1'b0;
    issue_valid    = 1'b0;
    issue_phase    = chan_eff;
    issue_tag.lo   = 1'b0;
    issue_tag.lane = lane_idx;
    res_write      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue_valid = 1'b1;
        if (cnt_q == LAST_CNT) begin
          issue_phase  = lo_issue_q;
          issue_tag.lo = 1'b1;
          state_d      = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cor_valid && cor_tag.lo) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: state_d = ST_MIX;
      ST_MIX:   state_d = ST_FINISH;
      ST_FINISH: begin
        if (!res_valid_q || res_pop_i) begin
          res_write = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        cnt_q <= '0;
      end else if (state_q == ST_ISSUE) begin
        cnt_q <= cnt_q + LCNT_W'(1);
      end
    end
  end

  // phase accumulators: used at their current value, then advanced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_CHANNELS; j++) begin
        chan_q[j] <= '0;
      end
      chip_q <= '0;
      lo_q   <= '0;
    end else if (cmd_pop_o) begin
      chip_q <= chip_eff + PHASE_BITS'(cfg_i.chip_step);
      lo_q   <= lo_eff + PHASE_BITS'(cfg_i.lo_step);
    end else if (state_q == ST_ISSUE && cnt_q != LAST_CNT) begin
      chan_q[lane_idx] <= chan_eff + inc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      clear_q    <= cmd_i.clear;
      last_q     <= cmd_i.last;
      lo_issue_q <= lo_eff;
      inc_q      <= inc0;
      sym_q      <= chip_pos ? $signed({1'b0, cfg_i.amplitude})
                             : -$signed({1'b0, cfg_i.amplitude});
    end else if (state_q == ST_ISSUE) begin
      inc_q <= inc_q + step_p;
    end

    priority if (cmd_pop_o) begin
      sum_i_q <= '0;
      sum_q_q <= '0;
    end else if (cor_valid && !cor_tag.lo && lane_en[cor_tag.lane]) begin
      sum_i_q <= sum_i_q + SUM_W'(trunc_q15(wide_t'(prod_i)));
      sum_q_q <= sum_q_q + SUM_W'(trunc_q15(wide_t'(prod_q)));
    end else begin
      sum_i_q <= sum_i_q;
      sum_q_q <= sum_q_q;
    end

    if (cor_valid && cor_tag.lo) begin
      lo_c_q <= cor_cos;
      lo_s_q <= cor_sin;
    end

    if (state_q == ST_CLAMP) begin
      oi_q   <= cl_i.val;
      oq_q   <= cl_q.val;
      sat1_q <= cl_i.hit | cl_q.hit;
    end

    if (state_q == ST_MIX) begin
      p_ic_q <= oi_q * lo_c_q;
      p_qs_q <= oq_q * lo_s_q;
      p_is_q <= oi_q * lo_s_q;
      p_qc_q <= oq_q * lo_c_q;
    end

    if (res_write) begin
      last_o <= last_q;
      if (cfg_i.lo_step == '0) begin
        i_sample_o  <= oi_q;
        q_sample_o  <= oq_q;
        saturated_o <= sat1_q;
      end else begin
        i_sample_o  <= mx_i.val;
        q_sample_o  <= mx_q.val;
        saturated_o <= sat1_q | mx_i.hit | mx_q.hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_write) begin
      res_valid_q <= 1'b1;
    end else if (res_pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;

`ifndef NO_ASSERTIONS
  a_lo_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cor_valid && cor_tag.lo) |-> (state_q == ST_DRAIN))
    else $error("LO rotator output outside drain");

  a_lane_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cor_valid && !cor_tag.lo) |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("lane rotator output after sample tail started");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (cnt_q <= LAST_CNT))
    else $error("lane issue counter overran");

  a_finish_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && (!res_valid_q || res_pop_i)) |=>
      (res_valid_q && state_q == ST_IDLE))
    else $error("result slot not filled on finish");
`endif

endmodule
`default_nettype wire

FILE: hdl/fdma_multichannel_nco_mixer_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fdma_multichannel_nco_mixer_top
// Multichannel FDMA NCO synthesizer with BPSK chip sign and LO offset mixing.
// -----------------------------------------------------------------------------
// Usage:
//   Input queue: one transaction per sample tick (push while full is low),
//   with clear_phase zeroing every phase accumulator before that sample and
//   chunk_last echoed to last_out_o. Up to four ticks wait in the input queue.
//   Result queue: while empty is low the composite I/Q sample, its saturation
//   flag and last_out_o are on the ports; pop takes them.
//   Config: cfg_valid_i/cfg_ready_o writes register cfg_index_i (0 active
//   mask, 1 channel step, 2 chip step, 3 LO step, 4 amplitude); ready is
//   always high. Write only while the block is idle.
// Sequence: one sample at a time, the engine issues the lane phases and then
//   the LO phase into the shared 19-stage CORDIC pipeline, waits for its
//   drain, then runs clamp, LO multiply and finish.
// Reset: phase accumulators clear to zero, registers take their defaults
//   (mask 0xFF, amplitude 700, steps 0); no sweep is needed.
// Stall: a finished sample waits in the result register; the engine holds
//   in its finish step and the input queue keeps accepting until full.
// -----------------------------------------------------------------------------
module fdma_multichannel_nco_mixer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              clear_phase_i,
  input  wire logic                              chunk_last_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output fdma_pkg::sample_t                      i_sample_o,
  output fdma_pkg::sample_t                      q_sample_o,
  output logic                                   saturated_o,
  output logic                                   last_out_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [fdma_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fdma_pkg::STEP_W-1:0]       cfg_data_i
);
  import fdma_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid, cmd_pop, res_valid, res_pop;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_mask  <= MASK_W'(255);
      cfg_q.channel_step <= '0;
      cfg_q.chip_step    <= '0;
      cfg_q.lo_step      <= '0;
      cfg_q.amplitude    <= AMP_W'(700);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ACTIVE_MASK:  cfg_q.active_mask  <= cfg_data_i[MASK_W-1:0];
        REG_CHANNEL_STEP: cfg_q.channel_step <= cfg_data_i;
        REG_CHIP_STEP:    cfg_q.chip_step    <= cfg_data_i;
        REG_LO_STEP:      cfg_q.lo_step      <= $signed(cfg_data_i);
        REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  fdma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .clear_phase_i (clear_phase_i),
    .chunk_last_i  (chunk_last_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

  fdma_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (res_pop),
    .res_valid_o (res_valid),
    .i_sample_o  (i_sample_o),
    .q_sample_o  (q_sample_o),
    .saturated_o (saturated_o),
    .last_o      (last_out_o)
  );

endmodule
`default_nettype wire
